// File: sv/rfrb_pkg.sv
// ----------------------------------------------------------------------------
// rfrb_pkg
// Shared types and constants for the received frame ring buffer.
// ----------------------------------------------------------------------------
package rfrb_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int SLOT_BYTES_DEF = 2048;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 12;
  localparam int WAIT_W = 4;

  typedef enum logic {
    REQ_RX   = 1'b0,
    REQ_READ = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_last;
  } in_item_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic [LEN_W-1:0]  frame_length;
    logic              frame_dropped;
    logic [WAIT_W-1:0] frames_waiting;
  } result_t;

endpackage

// File: sv/rfrb_mem.sv
// ----------------------------------------------------------------------------
// rfrb_mem
// Single-port frame byte store with registered read data.
// ----------------------------------------------------------------------------
module rfrb_mem import rfrb_pkg::*; #(
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/rfrb_ctrl.sv
// ----------------------------------------------------------------------------
// rfrb_ctrl
// Ring pointers, drop decision, slot lengths and the result register.
// ----------------------------------------------------------------------------
module rfrb_ctrl import rfrb_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF,
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int OFF_W     = $clog2(SLOT_BYTES),
  localparam int ADDR_W    = SLOT_W + OFF_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              start,
  input  in_item_t          item,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [BYTE_W-1:0] mem_wdata,
  input  logic [BYTE_W-1:0] mem_rdata,
  output logic              done,
  output result_t           result
);

  localparam int WC_W  = $clog2(SLOT_BYTES + 1);
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic              rx_enable;
  logic [SLOT_W-1:0] head, head_next, head_adv;
  logic [SLOT_W-1:0] tail, tail_next, tail_adv;
  logic              full, full_next;
  logic [WC_W-1:0]   write_count, write_count_next, wc_inc;
  logic              dropping, dropping_next, drop_now;
  logic [OFF_W-1:0]  read_offset, read_offset_next;
  logic [WC_W-1:0]   off_inc;
  logic [WC_W-1:0]   slot_len [SLOTS];
  logic [WC_W-1:0]   rd_len;
  logic              len_we;
  logic              rd_valid, rd_last;
  logic [CNT_W-1:0]  waiting_next;

  logic              res_valid, res_last, res_dropped;
  logic [LEN_W-1:0]  res_len;
  logic [WAIT_W-1:0] res_waiting;

  assign head_adv  = (head == SLOT_W'(SLOTS - 1)) ? '0 : head + 1'b1;
  assign tail_adv  = (tail == SLOT_W'(SLOTS - 1)) ? '0 : tail + 1'b1;
  assign rd_len    = slot_len[head];
  assign off_inc   = WC_W'(read_offset) + 1'b1;
  assign mem_wdata = item.rx_byte;

  always_comb begin
    head_next        = head;
    tail_next        = tail;
    full_next        = full;
    write_count_next = write_count;
    dropping_next    = dropping;
    read_offset_next = read_offset;
    wc_inc           = write_count;
    drop_now         = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = {tail, write_count[OFF_W-1:0]};
    len_we           = 1'b0;
    rd_valid         = 1'b0;
    rd_last          = 1'b0;
    if (cfg_we && cfg_wdata && !rx_enable) begin
      // enabling reception empties the ring
      head_next        = '0;
      tail_next        = '0;
      full_next        = 1'b0;
      write_count_next = '0;
      dropping_next    = 1'b0;
      read_offset_next = '0;
    end else if (start) begin
      if (item.req_type == REQ_RX) begin
        // drop decision is taken on the first byte only
        drop_now = dropping || (write_count == '0 && (!rx_enable || full));
        if (drop_now) begin
          dropping_next = !item.rx_last;
        end else begin
          if (write_count < WC_W'(SLOT_BYTES)) begin
            mem_we = 1'b1;
            wc_inc = write_count + 1'b1;
          end
          if (item.rx_last) begin
            len_we           = 1'b1;
            tail_next        = tail_adv;
            full_next        = (tail_adv == head);
            write_count_next = '0;
          end else begin
            write_count_next = wc_inc;
          end
        end
      end else if (full || head != tail) begin
        rd_valid = 1'b1;
        mem_addr = {head, read_offset};
        if (off_inc >= rd_len) begin
          rd_last          = 1'b1;
          head_next        = head_adv;
          full_next        = 1'b0;
          read_offset_next = '0;
        end else begin
          read_offset_next = read_offset + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (full_next) begin
      waiting_next = CNT_W'(SLOTS);
    end else if (tail_next >= head_next) begin
      waiting_next = CNT_W'(tail_next - head_next);
    end else begin
      waiting_next = CNT_W'(SLOTS) - CNT_W'(head_next - tail_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable   <= 1'b0;
      head        <= '0;
      tail        <= '0;
      full        <= 1'b0;
      write_count <= '0;
      dropping    <= 1'b0;
      read_offset <= '0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        rx_enable <= cfg_wdata;
      end
      head        <= head_next;
      tail        <= tail_next;
      full        <= full_next;
      write_count <= write_count_next;
      dropping    <= dropping_next;
      read_offset <= read_offset_next;
      done        <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      slot_len[tail] <= wc_inc;
    end
    res_valid   <= rd_valid;
    res_last    <= rd_last;
    res_len     <= rd_valid ? LEN_W'(rd_len) : '0;
    res_dropped <= drop_now;
    res_waiting <= WAIT_W'(waiting_next);
  end

  always_comb begin
    result.out_valid      = res_valid;
    result.out_byte       = res_valid ? mem_rdata : '0;
    result.out_last       = res_last;
    result.frame_length   = res_len;
    result.frame_dropped  = res_dropped;
    result.frames_waiting = res_waiting;
  end

endmodule

// File: sv/received_frame_ring_buffer.sv
// ----------------------------------------------------------------------------
// received_frame_ring_buffer
// Ring of frame slots: stores received frames byte by byte, reads them out
// byte by byte.
// ----------------------------------------------------------------------------
//  channel   signals                       handshake
//  -------   ----------------------------  --------------------------------
//  config    cfg_we, cfg_wdata (rx_enable) written when cfg_we is high
//  request   start, busy, item             taken when start && !busy
//  result    done, result                  one cycle wide, cannot be held
//
// One request per cycle; its result appears in the cycle after it is taken,
// set by the registered read of the byte store.
// busy is always low: the block never holds off a request.
// rst is synchronous and clears pointers, fill state and rx_enable; the
// byte and length stores are not cleared, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module received_frame_ring_buffer import rfrb_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     start,
  output logic     busy,
  input  in_item_t item,
  output logic     done,
  output result_t  result
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W = SLOT_W + $clog2(SLOT_BYTES);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  assign busy = 1'b0;

  rfrb_ctrl #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .item      (item),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .done      (done),
    .result    (result)
  );

  rfrb_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// File: sv/rfrb_chk.sv
// ----------------------------------------------------------------------------
// rfrb_chk
// Port-level checks for the received frame ring buffer.
// ----------------------------------------------------------------------------
module rfrb_chk import rfrb_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // every taken transaction yields exactly one result, in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after an accepted transaction");

  a_done_caused: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without an accepted transaction");

  // a result is never both a valid read byte and a dropped receive byte
  a_read_or_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.out_valid && result.frame_dropped))
    else $error("read result flagged as dropped");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (done && !result.out_valid) |->
      (result.out_byte == '0 && !result.out_last && result.frame_length == '0))
    else $error("read fields set without a valid byte");

  a_last_len: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_valid && result.out_last) |-> result.frame_length != '0)
    else $error("last byte of a zero-length frame");

endmodule

bind received_frame_ring_buffer rfrb_chk u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
